@@ src/ohm_pkg.sv @@
// ----------------------------------------------------------------------------
// ohm_pkg - shared types and codes of the open-addressing hash map
// Item structs, slot status codes, request kinds and controller commands.
// ----------------------------------------------------------------------------
package ohm_pkg;

    localparam logic [1:0] KIND_GET = 2'd0;
    localparam logic [1:0] KIND_SET = 2'd1;
    localparam logic [1:0] KIND_DEL = 2'd2;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_LIVE  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    // Outcome of a probe walk.
    localparam logic [1:0] PR_NONE = 2'd0;
    localparam logic [1:0] PR_MISS = 2'd1;
    localparam logic [1:0] PR_HIT  = 2'd2;

    // Slot writes.
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_CLR  = 2'd1;
    localparam logic [1:0] WR_TOMB = 2'd2;
    localparam logic [1:0] WR_LIVE = 2'd3;

    // Result item forms.
    localparam logic [2:0] RES_ZERO = 3'd0;
    localparam logic [2:0] RES_GET  = 3'd1;
    localparam logic [2:0] RES_DEL  = 3'd2;
    localparam logic [2:0] RES_SET  = 3'd3;
    localparam logic [2:0] RES_FULL = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key_id;
        logic [31:0] key_hash;
        logic [63:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [63:0] value_out;
        logic        inserted;
        logic        table_full;
    } t_out_item;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] hash;
        logic [63:0] value;
    } t_entry;

    typedef struct packed {
        logic       accept;
        logic       probe_req;
        logic       probe_scan;
        logic       mod_start;
        logic       probe_init;
        logic       rd_probe;
        logic       probe_eval;
        logic       grow_start;
        logic       rd_scan;
        logic       scan_inc;
        logic       grow_done;
        logic       moved_inc;
        logic       load_inc_new;
        logic [1:0] wr_kind;
        logic       out_load;
        logic [2:0] out_code;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       load_zero;
        logic       need_grow;
        logic       grow_over;
        logic       mod_done;
        logic       ev_hit;
        logic       ev_empty;
        logic       ev_last;
        logic       clr_last;
        logic       scan_end;
        logic       scan_live;
        logic [1:0] res;
        logic       out_free;
    } t_sts;

endpackage

@@ src/ohm_mod.sv @@
// ----------------------------------------------------------------------------
// ohm_mod - serial remainder unit
// Restoring division, one dividend bit per cycle, gives hash mod capacity.
// ----------------------------------------------------------------------------
module ohm_mod #(
    parameter int CW = 11,
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_num,
    input  logic [CW-1:0] i_den,
    output logic          o_done,
    output logic [AW-1:0] o_rem
);

    logic [31:0]   r_num;
    logic [CW-1:0] r_den;
    logic [CW-1:0] r_rem;
    logic [5:0]    r_cnt;
    logic [CW:0]   w_sh;
    logic [CW:0]   w_sub;

    assign w_sh  = {r_rem, r_num[31]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_cnt != 6'd0) begin
            r_num <= {r_num[30:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sub[CW-1:0];
            end else begin
                r_rem <= w_sh[CW-1:0];
            end
        end
    end

    assign o_done = (r_cnt == 6'd0);
    assign o_rem  = r_rem[AW-1:0];

endmodule

@@ src/ohm_dpath.sv @@
// ----------------------------------------------------------------------------
// ohm_dpath - hash map datapath
// Slot memories of both banks, table registers, probe walker and result.
// ----------------------------------------------------------------------------
module ohm_dpath #(
    parameter int MAX_CAPACITY   = 1024,
    parameter int FIRST_CAPACITY = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ohm_pkg::t_cmd     i_cmd,
    output ohm_pkg::t_sts     o_sts,
    input  ohm_pkg::t_in_item i_in,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output ohm_pkg::t_out_item o_out
);

    localparam int AW = $clog2(MAX_CAPACITY);
    localparam int CW = $clog2(MAX_CAPACITY + 1);
    localparam int SW = AW + 1;
    localparam int DEPTH = 2 ** SW;

    logic [1:0]           mem_st  [DEPTH];
    ohm_pkg::t_entry      mem_ent [DEPTH];

    ohm_pkg::t_in_item    r_req;
    logic [CW-1:0]        r_cap;
    logic [CW-1:0]        r_load;
    logic                 r_bank;
    logic [CW-1:0]        r_newcap;
    logic [CW-1:0]        r_moved;
    logic [CW-1:0]        r_scan;
    logic [31:0]          r_pk;
    logic [31:0]          r_ph;
    logic [63:0]          r_pv;
    logic                 r_pbank;
    logic [CW-1:0]        r_pcap;
    logic [AW-1:0]        r_idx;
    logic [CW-1:0]        r_cnt;
    logic                 r_have_tomb;
    logic [SW-1:0]        r_tomb;
    logic [SW-1:0]        r_slot;
    logic [1:0]           r_res;
    logic                 r_reuse;
    logic [63:0]          r_val;
    logic [1:0]           r_rd_st;
    ohm_pkg::t_entry      r_rd_ent;
    logic                 r_ovalid;
    ohm_pkg::t_out_item   r_out;
    ohm_pkg::t_out_item   n_out;

    logic [CW:0]          w_nc;
    logic [SW-1:0]        w_cur;
    logic [SW-1:0]        w_raddr;
    logic [SW-1:0]        w_waddr;
    logic [1:0]           w_wst;
    logic                 w_ev_hit;
    logic                 w_ev_empty;
    logic                 w_ev_tomb;
    logic [AW-1:0]        w_idx_nx;
    logic                 w_mod_done;
    logic [AW-1:0]        w_mod_rem;

    ohm_mod #(.CW(CW), .AW(AW)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mod_start),
        .i_num   (r_ph),
        .i_den   (r_pcap),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    assign w_nc = (r_cap == '0) ? (CW+1)'(FIRST_CAPACITY) : {r_cap, 1'b0};
    assign w_cur = {r_pbank, r_idx};
    assign w_raddr = i_cmd.rd_scan ? {r_bank, r_scan[AW-1:0]} : w_cur;
    assign w_ev_hit = (r_rd_st == ohm_pkg::ST_LIVE) && (r_rd_ent.key == r_pk);
    assign w_ev_empty = (r_rd_st == ohm_pkg::ST_EMPTY);
    assign w_ev_tomb = (r_rd_st == ohm_pkg::ST_TOMB);
    assign w_idx_nx = ((CW'(r_idx) + CW'(1)) == r_pcap) ? '0 : r_idx + AW'(1);

    always_comb begin
        w_waddr = r_slot;
        w_wst   = ohm_pkg::ST_LIVE;
        case (i_cmd.wr_kind)
            ohm_pkg::WR_CLR: begin
                w_waddr = {~r_bank, r_scan[AW-1:0]};
                w_wst   = ohm_pkg::ST_EMPTY;
            end
            ohm_pkg::WR_TOMB: begin
                w_wst = ohm_pkg::ST_TOMB;
            end
            default: begin
                w_wst = ohm_pkg::ST_LIVE;
            end
        endcase
    end

    // Slot memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_kind != ohm_pkg::WR_NONE) begin
            mem_st[w_waddr] <= w_wst;
        end
        if (i_cmd.wr_kind == ohm_pkg::WR_LIVE) begin
            mem_ent[r_slot] <= '{key: r_pk, hash: r_ph, value: r_pv};
        end
        if (i_cmd.rd_scan || i_cmd.rd_probe) begin
            r_rd_st  <= mem_st[w_raddr];
            r_rd_ent <= mem_ent[w_raddr];
        end
    end

    // Table registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= '0;
            r_load <= '0;
            r_bank <= 1'b0;
        end else if (i_cmd.grow_done) begin
            r_cap  <= r_newcap;
            r_load <= r_moved;
            r_bank <= ~r_bank;
        end else if (i_cmd.load_inc_new && (r_res == ohm_pkg::PR_MISS) && !r_reuse) begin
            r_load <= r_load + CW'(1);
        end
    end

    // Request, growth and probe registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in;
        end
        if (i_cmd.grow_start) begin
            r_newcap <= w_nc[CW-1:0];
            r_scan   <= '0;
            r_moved  <= '0;
        end else if (i_cmd.wr_kind == ohm_pkg::WR_CLR) begin
            r_scan <= (r_scan == r_newcap - CW'(1)) ? '0 : r_scan + CW'(1);
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + CW'(1);
        end
        if (i_cmd.moved_inc) begin
            r_moved <= r_moved + CW'(1);
        end
        if (i_cmd.probe_req) begin
            r_pk    <= r_req.key_id;
            r_ph    <= r_req.key_hash;
            r_pv    <= r_req.value_in;
            r_pbank <= r_bank;
            r_pcap  <= r_cap;
        end else if (i_cmd.probe_scan) begin
            r_pk    <= r_rd_ent.key;
            r_ph    <= r_rd_ent.hash;
            r_pv    <= r_rd_ent.value;
            r_pbank <= ~r_bank;
            r_pcap  <= r_newcap;
        end
        if (i_cmd.probe_init) begin
            r_idx       <= w_mod_rem;
            r_cnt       <= '0;
            r_have_tomb <= 1'b0;
        end else if (i_cmd.probe_eval) begin
            if (w_ev_hit) begin
                r_res  <= ohm_pkg::PR_HIT;
                r_slot <= w_cur;
                r_val  <= r_rd_ent.value;
            end else if (w_ev_empty) begin
                r_res   <= ohm_pkg::PR_MISS;
                r_slot  <= r_have_tomb ? r_tomb : w_cur;
                r_reuse <= r_have_tomb;
            end else begin
                // A tombstone or another live key: walk on, keep first tombstone.
                if (w_ev_tomb && !r_have_tomb) begin
                    r_have_tomb <= 1'b1;
                    r_tomb      <= w_cur;
                end
                r_res   <= (r_have_tomb || w_ev_tomb) ? ohm_pkg::PR_MISS : ohm_pkg::PR_NONE;
                r_slot  <= r_have_tomb ? r_tomb : w_cur;
                r_reuse <= 1'b1;
                r_idx   <= w_idx_nx;
                r_cnt   <= r_cnt + CW'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        n_out = '0;
        case (i_cmd.out_code)
            ohm_pkg::RES_GET: begin
                n_out.found     = 1'b1;
                n_out.value_out = r_val;
            end
            ohm_pkg::RES_DEL: begin
                n_out.found = 1'b1;
            end
            ohm_pkg::RES_SET: begin
                n_out.inserted = (r_res == ohm_pkg::PR_MISS);
            end
            ohm_pkg::RES_FULL: begin
                n_out.table_full = 1'b1;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_comb begin
        o_sts.kind      = r_req.kind;
        o_sts.load_zero = (r_load == '0);
        o_sts.need_grow = ({1'b0, r_load} + (CW+1)'(1)) > (CW+1)'(r_cap >> 1);
        o_sts.grow_over = w_nc > (CW+1)'(MAX_CAPACITY);
        o_sts.mod_done  = w_mod_done;
        o_sts.ev_hit    = w_ev_hit;
        o_sts.ev_empty  = w_ev_empty;
        o_sts.ev_last   = (r_cnt + CW'(1)) == r_pcap;
        o_sts.clr_last  = r_scan == (r_newcap - CW'(1));
        o_sts.scan_end  = r_scan == r_cap;
        o_sts.scan_live = (r_rd_st == ohm_pkg::ST_LIVE);
        o_sts.res       = r_res;
        o_sts.out_free  = !r_ovalid || i_out_ready;
    end

endmodule

@@ src/ohm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ohm_ctrl - hash map controller
// Sequences decode, growth sweeps, probe walks and the result hand-off.
// ----------------------------------------------------------------------------
module ohm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ohm_pkg::t_sts i_sts,
    output ohm_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_CLR      = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_EV  = 4'd4;
    localparam logic [3:0] S_GROW_END = 4'd5;
    localparam logic [3:0] S_MST      = 4'd6;
    localparam logic [3:0] S_MOD      = 4'd7;
    localparam logic [3:0] S_RD       = 4'd8;
    localparam logic [3:0] S_EV       = 4'd9;
    localparam logic [3:0] S_ACT      = 4'd10;
    localparam logic [3:0] S_FIN      = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_growing, n_growing;
    logic [2:0] r_code, n_code;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_growing <= 1'b0;
            r_code    <= ohm_pkg::RES_ZERO;
        end else begin
            r_state   <= n_state;
            r_growing <= n_growing;
            r_code    <= n_code;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_growing = r_growing;
        n_code    = r_code;
        o_cmd     = '0;
        o_cmd.out_code = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.kind)
                    ohm_pkg::KIND_GET, ohm_pkg::KIND_DEL: begin
                        if (i_sts.load_zero) begin
                            n_code  = ohm_pkg::RES_ZERO;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.probe_req = 1'b1;
                            n_state = S_MST;
                        end
                    end
                    ohm_pkg::KIND_SET: begin
                        if (i_sts.need_grow && i_sts.grow_over) begin
                            n_code  = ohm_pkg::RES_FULL;
                            n_state = S_FIN;
                        end else if (i_sts.need_grow) begin
                            o_cmd.grow_start = 1'b1;
                            n_growing = 1'b1;
                            n_state = S_CLR;
                        end else begin
                            o_cmd.probe_req = 1'b1;
                            n_state = S_MST;
                        end
                    end
                    default: begin
                        n_code  = ohm_pkg::RES_ZERO;
                        n_state = S_FIN;
                    end
                endcase
            end
            S_CLR: begin
                o_cmd.wr_kind = ohm_pkg::WR_CLR;
                if (i_sts.clr_last) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    n_state = S_GROW_END;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (i_sts.scan_live) begin
                    o_cmd.probe_scan = 1'b1;
                    n_state = S_MST;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_GROW_END: begin
                o_cmd.grow_done = 1'b1;
                n_growing = 1'b0;
                n_state = S_DEC;
            end
            S_MST: begin
                o_cmd.mod_start = 1'b1;
                n_state = S_MOD;
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_probe = 1'b1;
                n_state = S_EV;
            end
            S_EV: begin
                o_cmd.probe_eval = 1'b1;
                if (i_sts.ev_hit || i_sts.ev_empty || i_sts.ev_last) begin
                    n_state = S_ACT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_ACT: begin
                if (r_growing) begin
                    if (i_sts.res != ohm_pkg::PR_NONE) begin
                        o_cmd.wr_kind   = ohm_pkg::WR_LIVE;
                        o_cmd.moved_inc = 1'b1;
                    end
                    o_cmd.scan_inc = 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_FIN;
                    case (i_sts.kind)
                        ohm_pkg::KIND_GET: begin
                            n_code = (i_sts.res == ohm_pkg::PR_HIT) ?
                                     ohm_pkg::RES_GET : ohm_pkg::RES_ZERO;
                        end
                        ohm_pkg::KIND_DEL: begin
                            if (i_sts.res == ohm_pkg::PR_HIT) begin
                                o_cmd.wr_kind = ohm_pkg::WR_TOMB;
                                n_code = ohm_pkg::RES_DEL;
                            end else begin
                                n_code = ohm_pkg::RES_ZERO;
                            end
                        end
                        default: begin
                            if (i_sts.res == ohm_pkg::PR_NONE) begin
                                n_code = ohm_pkg::RES_FULL;
                            end else begin
                                o_cmd.wr_kind      = ohm_pkg::WR_LIVE;
                                o_cmd.load_inc_new = 1'b1;
                                n_code = ohm_pkg::RES_SET;
                            end
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/open_addressing_hash_map.sv @@
// ----------------------------------------------------------------------------
// open_addressing_hash_map - linear-probing key/value map with tombstones
// Get, set and delete requests over two slot banks that swap on growth.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   request   in         i_in_valid / o_in_ready    i_in  (kind, key, hash, value)
//   result    out        o_out_valid / i_out_ready  o_out (found, value, new, full)
//
// One item is worked on at a time. An item is decoded and started, passes the
// serial remainder unit (hash mod capacity, one bit a cycle), then visits slots
// in turn with a read and an evaluation each, as the slot memories give one
// registered read per cycle. A growth first clears every slot of the new bank,
// then reads each old slot and runs a full probe for each live entry that
// moves. Reset is synchronous; no clearing pass follows it, because a bank
// is always swept empty by a growth before it is first read. The result waits
// in an output register, so a stalled consumer only holds the block at its end.
// ----------------------------------------------------------------------------
module open_addressing_hash_map #(
    parameter int MAX_CAPACITY   = 1024,
    parameter int FIRST_CAPACITY = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ohm_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ohm_pkg::t_out_item o_out
);

    ohm_pkg::t_cmd w_cmd;
    ohm_pkg::t_sts w_sts;

    // The controller owns sequencing; the datapath owns all storage.
    ohm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ohm_dpath #(
        .MAX_CAPACITY   (MAX_CAPACITY),
        .FIRST_CAPACITY (FIRST_CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
